/* hw/rtl/nsem_pkg.sv */
// types and constants shared by the named counting semaphore table
package nsem_pkg;

  localparam int NUM_ENTRIES = 10;
  localparam int NAME_BYTES  = 8;

  localparam int KIND_W    = 2;
  localparam int NAME_W    = 64;
  localparam int INIT_W    = 15;
  localparam int HANDLE_W  = 4;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 16;
  localparam int IDX_W     = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int MEM_W     = COUNT_W + NAME_W;

  localparam logic [KIND_W-1:0] OP_OPEN   = 2'd0;
  localparam logic [KIND_W-1:0] OP_WAIT   = 2'd1;
  localparam logic [KIND_W-1:0] OP_POST   = 2'd2;
  localparam logic [KIND_W-1:0] OP_UNLINK = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BADHANDLE = 2'd2;

  localparam logic signed [COUNT_W-1:0] COUNT_MAX = 16'sh7FFF;
  localparam logic signed [COUNT_W-1:0] COUNT_MIN = 16'sh8000;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [NAME_W-1:0]   label;
    logic [INIT_W-1:0]   initial_count;
    logic [HANDLE_W-1:0] handle;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]        status;
    logic [HANDLE_W-1:0]        result_handle;
    logic                       must_block;
    logic                       wake_one;
    logic signed [COUNT_W-1:0]  count_after;
  } rsp_t;

endpackage

/* hw/rtl/named_counting_semaphore_table.sv */
// named counting semaphore table: top level with entry memory and sequencer
//
// usage
// - request channel: in_valid_i / in_stall_o carry one req_t (kind, name,
//   initial count, handle); a transfer happens when valid is high and stall low
// - response channel: out_valid_o / out_stall_i carry one rsp_t per request,
//   in request order, from an output register
// - one request is worked on at a time; the next request is taken as soon as
//   the previous response has been placed in the output register, even while
//   that response still waits for the receiver
// - open and unlink scan the entry memory one entry a cycle through its single
//   read port, stopping early at the first in-use entry that carries the name
// - wait and post do one read-modify-write of the addressed entry; a bad
//   handle is answered without reading the entry
// - reset clears every in-use flag at once, so the table is empty straight
//   after reset; the count and name memory needs no clearing pass since a
//   free entry is never read for a result
// - a stalled receiver holds the response in the output register; a finished
//   request then waits until that register is free, and no new request is
//   taken meanwhile
module named_counting_semaphore_table (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  nsem_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output nsem_pkg::rsp_t out_rsp_o
);
  import nsem_pkg::*;

  // one-hot sequencer states
  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_MODIFY = 4'b0100,
    S_RESP   = 4'b1000
  } state_e;

  // names are compared in normal form: bytes past the first zero are zero
  function automatic logic [NAME_W-1:0] norm_name(input logic [NAME_W-1:0] raw);
    logic [NAME_W-1:0] res;
    logic              keep;
    res  = '0;
    keep = 1'b1;
    for (int b = 0; b < NAME_W / 8; b++) begin
      keep = keep && (b < NAME_BYTES) && (raw[b*8 +: 8] != 8'd0);
      res[b*8 +: 8] = keep ? raw[b*8 +: 8] : 8'd0;
    end
    return res;
  endfunction

  state_e state_q, state_d;
  req_t   req_q, req_d;
  rsp_t   res_q, res_d;
  rsp_t   out_q, out_d;
  logic   out_valid_q, out_valid_d;

  // scan bookkeeping: idx_q is the next address to read, chk_* tags read data
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             issued_q, issued_d;
  logic             chk_valid_q, chk_valid_d;
  logic [IDX_W-1:0] chk_idx_q, chk_idx_d;

  // in-use flags live in flops so reset empties the table immediately
  logic [NUM_ENTRIES-1:0] in_use_q, in_use_d;

  // entry memory: {count, name}, one read and one write port, registered read
  logic [MEM_W-1:0] sem_mem [NUM_ENTRIES];
  logic [MEM_W-1:0] rd_data_q;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [MEM_W-1:0] wr_data;

  logic signed [COUNT_W-1:0] rd_count;
  logic [NAME_W-1:0]         rd_name;
  logic signed [COUNT_W-1:0] count_new;
  logic                      name_hit;
  logic                      any_free;
  logic [IDX_W-1:0]          free_idx;
  logic [IDX_W-1:0]          in_hidx;
  logic [IDX_W-1:0]          req_hidx;
  logic                      bad_handle;

  assign rd_count = rd_data_q[MEM_W-1 -: COUNT_W];
  assign rd_name  = rd_data_q[NAME_W-1:0];
  assign in_hidx  = in_req_i.handle[IDX_W-1:0];
  assign req_hidx = req_q.handle[IDX_W-1:0];

  // handle out of range or pointing at a free entry
  assign bad_handle = (int'(in_req_i.handle) >= NUM_ENTRIES) || !in_use_q[in_hidx];

  // the entry read last cycle is in use and carries the requested name
  assign name_hit = chk_valid_q && in_use_q[chk_idx_q] && (rd_name == req_q.label);

  // lowest free entry
  always_comb begin
    any_free = 1'b0;
    free_idx = '0;
    for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
      if (!in_use_q[i]) begin
        any_free = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  // saturating wait / post on the count just read
  always_comb begin
    count_new = rd_count;
    if (req_q.kind == OP_WAIT) begin
      if (rd_count != COUNT_MIN) begin
        count_new = rd_count - 16'sd1;
      end
    end else begin
      if (rd_count != COUNT_MAX) begin
        count_new = rd_count + 16'sd1;
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    res_d       = res_q;
    idx_d       = idx_q;
    issued_d    = issued_q;
    chk_valid_d = 1'b0;
    chk_idx_d   = chk_idx_q;
    in_use_d    = in_use_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    rd_en       = 1'b0;
    rd_addr     = idx_q;
    wr_en       = 1'b0;
    wr_addr     = req_hidx;
    wr_data     = rd_data_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d       = in_req_i;
          req_d.label = norm_name(in_req_i.label);
          res_d       = '0;
          case (in_req_i.kind)
            OP_OPEN, OP_UNLINK: begin
              idx_d    = '0;
              issued_d = 1'b0;
              state_d  = S_SCAN;
            end
            OP_WAIT, OP_POST: begin
              if (bad_handle) begin
                res_d.status = ST_BADHANDLE;
                state_d      = S_RESP;
              end else begin
                rd_en   = 1'b1;
                rd_addr = in_hidx;
                state_d = S_MODIFY;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      S_SCAN: begin
        // issue the next read while checking the previous one
        if (!issued_q) begin
          rd_en       = 1'b1;
          rd_addr     = idx_q;
          chk_valid_d = 1'b1;
          chk_idx_d   = idx_q;
          if (idx_q == IDX_W'(NUM_ENTRIES - 1)) begin
            issued_d = 1'b1;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
        if (name_hit) begin
          chk_valid_d = 1'b0;
          state_d     = S_RESP;
          if (req_q.kind == OP_OPEN) begin
            res_d.result_handle = HANDLE_W'(chk_idx_q);
            res_d.count_after   = rd_count;
          end else begin
            in_use_d[chk_idx_q] = 1'b0;
          end
        end else if (chk_valid_q && chk_idx_q == IDX_W'(NUM_ENTRIES - 1)) begin
          chk_valid_d = 1'b0;
          state_d     = S_RESP;
          if (req_q.kind == OP_OPEN && any_free) begin
            // allocate the lowest free entry
            wr_en                = 1'b1;
            wr_addr              = free_idx;
            wr_data              = {COUNT_W'(req_q.initial_count), req_q.label};
            in_use_d[free_idx]   = 1'b1;
            res_d.result_handle  = HANDLE_W'(free_idx);
            res_d.count_after    = COUNT_W'(req_q.initial_count);
          end else begin
            res_d.status = ST_MISS;
          end
        end
      end

      S_MODIFY: begin
        wr_en             = 1'b1;
        wr_addr           = req_hidx;
        wr_data           = {count_new, rd_name};
        res_d.count_after = count_new;
        res_d.must_block  = (req_q.kind == OP_WAIT) && count_new[COUNT_W-1];
        res_d.wake_one    = (req_q.kind == OP_POST) && (count_new <= 16'sd0);
        state_d           = S_RESP;
      end

      S_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      in_use_q    <= '0;
      issued_q    <= 1'b0;
      chk_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      in_use_q    <= in_use_d;
      issued_q    <= issued_d;
      chk_valid_q <= chk_valid_d;
      idx_q       <= idx_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    res_q     <= res_d;
    out_q     <= out_d;
    chk_idx_q <= chk_idx_d;
  end

  // entry memory
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      sem_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= sem_mem[rd_addr];
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

/* bench/named_counting_semaphore_table_test.sv */
// self-checking testbench for the named counting semaphore table
module named_counting_semaphore_table_test;
  import nsem_pkg::*;

  // sender idling and receiver stalls stop once this few requests are left
  localparam int QUIET_TAIL = 40;
  // longest time one request can spend in the block without receiver stalls, scans included
  localparam int BLOCK_LATENCY = NUM_ENTRIES + 3;
  localparam int POOL_SIZE = 14;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  req_t in_req_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  rsp_t out_rsp_o;

  // requests waiting to be driven, and responses still owed by the block
  req_t pending_req[$];
  rsp_t owed_rsp[$];

  // shadow copy of the semaphore table
  logic                      sem_used  [NUM_ENTRIES];
  logic signed [COUNT_W-1:0] sem_count [NUM_ENTRIES];
  logic [NAME_W-1:0]         sem_label [NUM_ENTRIES];

  int error_count = 0;
  int gap_left = 0;
  int stall_left = 0;
  bit sender_busy;
  rsp_t want_rsp;

  named_counting_semaphore_table dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    error_count++;
    $display("mismatch in %s: got %0h, expected %0h at %0t", what, got, want, $time);
  endtask

  task automatic add_item(input logic [KIND_W-1:0] k, input logic [NAME_W-1:0] nm,
                          input logic [INIT_W-1:0] ic, input logic [HANDLE_W-1:0] h);
    req_t item;
    item.kind          = k;
    item.label         = nm;
    item.initial_count = ic;
    item.handle        = h;
    pending_req.push_back(item);
  endtask

  // applies one request to the shadow table and returns the response it earns
  function automatic rsp_t apply_sem_op(input req_t r);
    rsp_t p;
    logic [NAME_W-1:0] nm;
    logic signed [COUNT_W-1:0] c;
    int hit;
    bit ended;
    p = '0;
    // names stop at the first zero byte, like a c string
    nm = '0;
    ended = 1'b0;
    for (int b = 0; b < NAME_BYTES; b++) begin
      if (r.label[8*b +: 8] == 8'h00) ended = 1'b1;
      if (!ended) nm[8*b +: 8] = r.label[8*b +: 8];
    end
    hit = -1;
    for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
      if (sem_used[i] && sem_label[i] == nm) hit = i;
    end
    case (r.kind)
      OP_OPEN: begin
        // no match anywhere: take the lowest free entry
        if (hit < 0) begin
          for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
            if (!sem_used[i]) hit = i;
          end
          if (hit >= 0) begin
            sem_used[hit]  = 1'b1;
            sem_count[hit] = {1'b0, r.initial_count};
            sem_label[hit] = nm;
          end
        end
        if (hit < 0) begin
          p.status = ST_MISS;
        end else begin
          p.result_handle = HANDLE_W'(hit);
          p.count_after   = sem_count[hit];
        end
      end
      OP_WAIT, OP_POST: begin
        if (r.handle >= NUM_ENTRIES) begin
          p.status = ST_BADHANDLE;
        end else if (!sem_used[r.handle]) begin
          p.status = ST_BADHANDLE;
        end else begin
          c = sem_count[r.handle];
          if (r.kind == OP_WAIT) begin
            if (c != COUNT_MIN) c = c - 16'sd1;
            p.must_block = (c < 0);
          end else begin
            if (c != COUNT_MAX) c = c + 16'sd1;
            p.wake_one = (c <= 0);
          end
          sem_count[r.handle] = c;
          p.count_after = c;
        end
      end
      OP_UNLINK: begin
        if (hit < 0) begin
          p.status = ST_MISS;
        end else begin
          sem_used[hit]  = 1'b0;
          sem_count[hit] = '0;
          sem_label[hit] = '0;
        end
      end
      default: begin
      end
    endcase
    return p;
  endfunction

  // request driver: payload only moves after a transfer or while valid is low
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_req_i   <= '0;
      gap_left   = 0;
    end else begin
      sender_busy = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        owed_rsp.push_back(apply_sem_op(in_req_i));
        sender_busy = 1'b0;
      end
      if (!sender_busy) begin
        if (gap_left == 0 && pending_req.size() > QUIET_TAIL && $urandom_range(0, 7) == 0)
          gap_left = $urandom_range(1, 16);
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_req.size() > 0) begin
          in_valid_i <= 1'b1;
          in_req_i   <= pending_req.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // response monitor and receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (owed_rsp.size() == 0) begin
          report_mismatch("unrequested response", 64'(out_rsp_o), 64'd0);
        end else begin
          want_rsp = owed_rsp.pop_front();
          if (out_rsp_o.status !== want_rsp.status)
            report_mismatch("status", 64'(out_rsp_o.status), 64'(want_rsp.status));
          if (out_rsp_o.result_handle !== want_rsp.result_handle)
            report_mismatch("result_handle", 64'(out_rsp_o.result_handle),
                            64'(want_rsp.result_handle));
          if (out_rsp_o.must_block !== want_rsp.must_block)
            report_mismatch("must_block", 64'(out_rsp_o.must_block),
                            64'(want_rsp.must_block));
          if (out_rsp_o.wake_one !== want_rsp.wake_one)
            report_mismatch("wake_one", 64'(out_rsp_o.wake_one), 64'(want_rsp.wake_one));
          if (out_rsp_o.count_after !== want_rsp.count_after)
            report_mismatch("count_after", 64'(out_rsp_o.count_after),
                            64'(want_rsp.count_after));
        end
      end
      if (stall_left == 0 && pending_req.size() > QUIET_TAIL && $urandom_range(0, 11) == 0)
        stall_left = $urandom_range(1, 16);
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #400000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    logic [NAME_W-1:0] name_pool [POOL_SIZE];
    logic [NAME_W-1:0] nm;
    logic [INIT_W-1:0] ic;
    int r;
    int len;

    for (int i = 0; i < NUM_ENTRIES; i++) begin
      sem_used[i]  = 1'b0;
      sem_count[i] = '0;
      sem_label[i] = '0;
    end

    // directed: hit on reopen, block and wake, bad handles, unknown name
    add_item(OP_OPEN, 64'h41, '0, '0);
    add_item(OP_OPEN, 64'h41, 15'd9, 4'd7);
    add_item(OP_WAIT, '0, '0, 4'd0);
    add_item(OP_POST, '1, '1, 4'd0);
    add_item(OP_POST, '0, '0, 4'd0);
    add_item(OP_WAIT, 64'h41, '0, 4'd15);
    add_item(OP_POST, '0, '0, HANDLE_W'(NUM_ENTRIES - 1));
    add_item(OP_UNLINK, 64'h42, '0, '0);
    // widest name and largest start count, then post clamps at the top
    add_item(OP_OPEN, '1, '1, '0);
    add_item(OP_POST, '0, '0, 4'd1);
    // empty name, and bytes beyond a zero byte that must be ignored
    add_item(OP_OPEN, '0, 15'd5, '0);
    add_item(OP_OPEN, 64'h1234_0000_0000_0000, '0, '0);
    add_item(OP_OPEN, 64'hFF00_0000_0012_3441, 15'd7, '0);
    add_item(OP_OPEN, 64'h0000_0000_0012_3441, '0, '0);
    // fill the rest of the table, then one open too many
    for (int i = 4; i < NUM_ENTRIES; i++)
      add_item(OP_OPEN, NAME_W'(8'h30 + i), INIT_W'(i), '0);
    add_item(OP_OPEN, 64'h99, '0, '0);
    add_item(OP_UNLINK, '1, '0, '0);
    add_item(OP_WAIT, '0, '0, 4'd1);
    add_item(OP_UNLINK, 64'h5500, '0, '0);
    add_item(OP_OPEN, 64'h99, '0, '0);

    // a few waits with junk in the unused fields, then one post
    repeat (4) add_item(OP_WAIT, {$urandom, $urandom}, INIT_W'($urandom), 4'd1);
    add_item(OP_POST, '0, '0, 4'd1);

    // clear the directed names out again
    add_item(OP_UNLINK, 64'h41, '0, '0);
    add_item(OP_UNLINK, 64'h99, '0, '0);
    add_item(OP_UNLINK, 64'h12_3441, '0, '0);
    for (int i = 4; i < NUM_ENTRIES; i++)
      add_item(OP_UNLINK, NAME_W'(8'h30 + i), '0, '0);

    // name pool a bit larger than the table so that it fills up now and then
    for (int p = 0; p < POOL_SIZE; p++) begin
      name_pool[p] = '0;
      len = (p == 0) ? 0 : $urandom_range(1, NAME_BYTES);
      for (int b = 0; b < len; b++)
        name_pool[p][8*b +: 8] = 8'($urandom_range(1, 255));
    end

    // random traffic, mostly well formed over the pool
    repeat (360) begin
      r  = $urandom_range(0, 99);
      nm = name_pool[$urandom_range(0, POOL_SIZE - 1)];
      len = 0;
      while (len < NAME_BYTES && nm[8*len +: 8] != 8'h00) len++;
      // sometimes garbage past the terminating zero
      if (len < NAME_BYTES - 1 && $urandom_range(0, 2) == 0) begin
        for (int b = len + 1; b < NAME_BYTES; b++)
          nm[8*b +: 8] = 8'($urandom_range(0, 255));
      end
      ic = ($urandom_range(0, 7) == 0) ? INIT_W'($urandom) : INIT_W'($urandom_range(0, 3));
      if (r < 8) begin
        add_item(KIND_W'($urandom_range(0, 3)), {$urandom, $urandom}, INIT_W'($urandom),
                 HANDLE_W'($urandom_range(0, 15)));
      end else if (r < 38) begin
        add_item(OP_OPEN, nm, ic, HANDLE_W'($urandom));
      end else if (r < 88) begin
        add_item((r < 63) ? OP_WAIT : OP_POST, {$urandom, $urandom}, INIT_W'($urandom),
                 ($urandom_range(0, 9) == 0) ? HANDLE_W'($urandom_range(0, 15))
                                             : HANDLE_W'($urandom_range(0, NUM_ENTRIES - 1)));
      end else begin
        add_item(OP_UNLINK, nm, INIT_W'($urandom), HANDLE_W'($urandom));
      end
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // every request handed over, every response in, then let the block settle
    while (pending_req.size() != 0 || in_valid_i) @(posedge clk_i);
    while (owed_rsp.size() != 0) @(posedge clk_i);
    repeat (3 * BLOCK_LATENCY) @(posedge clk_i);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/nsem_pkg.sv
hw/rtl/named_counting_semaphore_table.sv
bench/named_counting_semaphore_table_test.sv
